/* rtl/eva_pkg.sv */
// ----------------------------------------------------------------------------
// eva_pkg
// Shared constants, codes and types of the energy voice activity detector.
// ----------------------------------------------------------------------------
`default_nettype none

package eva_pkg;

  localparam int SAMPLES_PER_MS = 16;
  localparam int MAX_FRAME_MS   = 60;
  localparam int MAX_LEN        = SAMPLES_PER_MS * MAX_FRAME_MS;
  localparam int LEN_W          = $clog2(MAX_LEN + 1);
  localparam int MAG_W          = 17;
  localparam int SUM_W          = $clog2(MAX_LEN * 32768 + 1);
  localparam int PROD_W         = 16 + LEN_W;
  localparam int CMP_W          = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  localparam logic [15:0] THRESHOLD_RST = 16'd1000;
  localparam logic [15:0] SILENCE_RST   = 16'd2000;
  localparam logic [5:0]  FRAME_MS_RST  = 6'd20;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SILENCE   = 2'd1;
  localparam logic [1:0] REG_FRAME_MS  = 2'd2;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  localparam logic [1:0] EV_FRAME = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_VAD    = 2'd1;
  localparam logic [1:0] CAUSE_MANUAL = 2'd2;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] silence_limit;
    logic [5:0]  frame_ms;
  } cfg_t;

  typedef struct packed {
    logic        frame_silent;
    logic [15:0] quiet_ms;
    logic [1:0]  stop_reason;
    logic        capturing;
    logic [1:0]  event_kind;
  } result_t;

endpackage

`default_nettype wire

/* rtl/eva_cfg_regs.sv */
// ----------------------------------------------------------------------------
// eva_cfg_regs
// Configuration register file: threshold, silence limit and frame length.
// ----------------------------------------------------------------------------
`default_nettype none

module eva_cfg_regs (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr_en,
  input  wire [1:0]        wr_index,
  input  wire [15:0]       wr_data,
  output eva_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold     <= eva_pkg::THRESHOLD_RST;
      cfg.silence_limit <= eva_pkg::SILENCE_RST;
      cfg.frame_ms      <= eva_pkg::FRAME_MS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        eva_pkg::REG_THRESHOLD: cfg.threshold     <= wr_data;
        eva_pkg::REG_SILENCE:   cfg.silence_limit <= wr_data;
        eva_pkg::REG_FRAME_MS:  cfg.frame_ms      <= wr_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/eva_datapath.sv */
// ----------------------------------------------------------------------------
// eva_datapath
// Frame energy accumulation, silence timing and capture control state.
// ----------------------------------------------------------------------------
`default_nettype none

module eva_datapath (
  input  wire                clk,
  input  wire                rst,
  input  wire                step,
  input  wire [1:0]          opcode,
  input  wire [15:0]         sample,
  input  eva_pkg::cfg_t      cfg,
  output logic               has_result,
  output eva_pkg::result_t   result
);

  logic                       capture_active, capture_active_next;
  logic [1:0]                 stop_cause, stop_cause_next;
  logic [15:0]                silent_time, silent_time_next;
  logic [eva_pkg::SUM_W-1:0]  abs_sum, abs_sum_next;
  logic [eva_pkg::LEN_W-1:0]  sample_index, sample_index_next;

  logic [16:0]                sx;
  logic [eva_pkg::MAG_W-1:0]  mag;
  logic [5:0]                 fms;
  logic [eva_pkg::LEN_W-1:0]  len;
  logic [eva_pkg::SUM_W-1:0]  sum_inc;
  logic [eva_pkg::LEN_W-1:0]  idx_inc;
  logic [eva_pkg::PROD_W-1:0] thr_len;
  logic                       frame_done;
  logic                       silent;
  logic [16:0]                t_add;
  logic [15:0]                t_sat;

  always_comb begin
    sx  = {sample[15], sample};
    mag = sample[15] ? (17'd0 - sx) : sx;
    if (cfg.frame_ms == 6'd0) begin
      fms = 6'd1;
    end else if (cfg.frame_ms > 6'(eva_pkg::MAX_FRAME_MS)) begin
      fms = 6'(eva_pkg::MAX_FRAME_MS);
    end else begin
      fms = cfg.frame_ms;
    end
    len        = eva_pkg::LEN_W'(eva_pkg::SAMPLES_PER_MS) * eva_pkg::LEN_W'(fms);
    sum_inc    = abs_sum + eva_pkg::SUM_W'(mag);
    idx_inc    = sample_index + eva_pkg::LEN_W'(1);
    frame_done = idx_inc >= len;
    thr_len    = eva_pkg::PROD_W'(cfg.threshold) * eva_pkg::PROD_W'(len);
    silent     = eva_pkg::CMP_W'(sum_inc) < eva_pkg::CMP_W'(thr_len);
    t_add      = {1'b0, silent_time} + 17'(fms);
    t_sat      = t_add[16] ? 16'hFFFF : t_add[15:0];
  end

  always_comb begin
    capture_active_next = capture_active;
    stop_cause_next     = stop_cause;
    silent_time_next    = silent_time;
    abs_sum_next        = abs_sum;
    sample_index_next   = sample_index;
    has_result          = 1'b0;
    result.frame_silent = 1'b0;
    result.event_kind   = eva_pkg::EV_FRAME;
    unique case (opcode)
      eva_pkg::OP_START: begin
        capture_active_next = 1'b1;
        stop_cause_next     = eva_pkg::CAUSE_NONE;
        silent_time_next    = 16'd0;
        abs_sum_next        = '0;
        sample_index_next   = '0;
        has_result          = 1'b1;
        result.event_kind   = eva_pkg::EV_START;
      end
      eva_pkg::OP_STOP: begin
        if (capture_active) begin
          capture_active_next = 1'b0;
          stop_cause_next     = eva_pkg::CAUSE_MANUAL;
        end
        has_result        = 1'b1;
        result.event_kind = eva_pkg::EV_STOP;
      end
      eva_pkg::OP_SAMPLE: begin
        if (capture_active) begin
          if (frame_done) begin
            abs_sum_next        = '0;
            sample_index_next   = '0;
            has_result          = 1'b1;
            result.frame_silent = silent;
            if (silent) begin
              silent_time_next = t_sat;
              if (t_sat >= cfg.silence_limit) begin
                capture_active_next = 1'b0;
                stop_cause_next     = eva_pkg::CAUSE_VAD;
              end
            end else begin
              silent_time_next = 16'd0;
            end
          end else begin
            abs_sum_next      = sum_inc;
            sample_index_next = idx_inc;
          end
        end
      end
      default: ;
    endcase
    result.quiet_ms    = silent_time_next;
    result.stop_reason = stop_cause_next;
    result.capturing   = capture_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_active <= 1'b0;
      stop_cause     <= eva_pkg::CAUSE_NONE;
      silent_time    <= 16'd0;
      abs_sum        <= '0;
      sample_index   <= '0;
    end else if (step) begin
      capture_active <= capture_active_next;
      stop_cause     <= stop_cause_next;
      silent_time    <= silent_time_next;
      abs_sum        <= abs_sum_next;
      sample_index   <= sample_index_next;
    end
  end

  a_cause_code: assert property (@(posedge clk) disable iff (rst)
    stop_cause != 2'd3)
    else $error("invalid stop cause");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    step && opcode == eva_pkg::OP_START |=>
      capture_active && silent_time == 16'd0 && sample_index == '0 && abs_sum == '0)
    else $error("start did not clear state");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    sample_index < eva_pkg::LEN_W'(eva_pkg::MAX_LEN))
    else $error("sample index out of range");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    step && !capture_active && opcode == eva_pkg::OP_SAMPLE |=>
      $stable(abs_sum) && $stable(sample_index) && $stable(silent_time))
    else $error("idle sample changed state");

endmodule

`default_nettype wire

/* rtl/eva_out_reg.sv */
// ----------------------------------------------------------------------------
// eva_out_reg
// Result register driving the master stream side.
// ----------------------------------------------------------------------------
`default_nettype none

module eva_out_reg (
  input  wire                clk,
  input  wire                rst,
  input  wire                load,
  input  eva_pkg::result_t   din,
  output logic               free,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [23:0]        m_tdata,
  output logic [1:0]         m_tuser
);

  eva_pkg::result_t hold;

  assign free    = !m_tvalid || m_tready;
  assign m_tdata = {4'd0, hold.capturing, hold.stop_reason, hold.quiet_ms,
                    hold.frame_silent};
  assign m_tuser = hold.event_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= din;
    end
  end

endmodule

`default_nettype wire

/* rtl/energy_voice_activity_detector_core.sv */
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_core
// Energy based voice activity detector with capture start/stop control.
// ----------------------------------------------------------------------------
// Each input beat is held in the input register, then its result in the result register.
// Throughput: one input beat per cycle, unless a beat with a result waits for the result register to be free.
// Items that produce no result pass without waiting for the result register.
// Reset (synchronous): capture off, counters cleared, config at default values.
`default_nettype none

module energy_voice_activity_detector_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // sample[15:0]
  input  wire  [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // frame_silent[0], quiet_ms[16:1],
                                 // stop_reason[18:17], capturing[19], zero[23:20]
  output logic [1:0]  m_tuser,   // event_kind[1:0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  eva_pkg::cfg_t    cfg;
  eva_pkg::result_t result;
  logic             in_valid;
  logic [1:0]       in_opcode;
  logic [15:0]      in_sample;
  logic             has_result;
  logic             out_free;
  logic             advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!has_result || out_free);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode <= s_tuser;
      in_sample <= s_tdata;
    end
  end

  eva_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  eva_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .opcode     (in_opcode),
    .sample     (in_sample),
    .cfg        (cfg),
    .has_result (has_result),
    .result     (result)
  );

  eva_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && has_result),
    .din      (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
